@@ hdl/clock_mux_divider_rate_select_core_assert.svh @@
// assertion macros for the rate select core checker
`ifndef CLOCK_MUX_DIVIDER_RATE_SELECT_CORE_ASSERT_SVH
`define CLOCK_MUX_DIVIDER_RATE_SELECT_CORE_ASSERT_SVH
// next-cycle implication, masked while reset is high
`define CDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rate select core check failed");
// next-cycle implication that also holds through reset
`define CDR_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rate select core reset check failed");
`endif

@@ hdl/cdr_pkg.sv @@
`default_nettype none
package cdr_pkg;
  localparam int RATE_BITS = 32;
  localparam int SEL_BITS = 3;
  localparam int DIV_BITS = 8;
  localparam int MAX_DIV_BITS = 8;
  localparam int PARENT_COUNT = 1 << SEL_BITS;
  localparam int DCNT_BITS = $clog2(RATE_BITS + 1);

  localparam logic [1:0] KIND_RATE = 2'd0;
  localparam logic [1:0] KIND_PARENT = 2'd1;
  localparam logic [1:0] KIND_GATE = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic REG_MUX_WIDTH = 1'b0;
  localparam logic REG_DIV_WIDTH = 1'b1;

  typedef logic [RATE_BITS-1:0] rate_t;

  typedef struct packed {
    logic  start;
    rate_t num;
    rate_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    rate_t quo;
    logic  rem_nz;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/cdr_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module cdr_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cdr_pkg::div_req_t req,
  output cdr_pkg::div_rsp_t      rsp
);
  logic [cdr_pkg::RATE_BITS:0] rem;
  cdr_pkg::rate_t quo;
  cdr_pkg::rate_t den;
  logic [cdr_pkg::DCNT_BITS-1:0] cnt;
  logic busy;
  logic done;
  logic [cdr_pkg::RATE_BITS:0] rem_sh;
  logic [cdr_pkg::RATE_BITS:0] rem_sub;
  logic fits;

  always_comb begin
    rem_sh = {rem[cdr_pkg::RATE_BITS-1:0], quo[cdr_pkg::RATE_BITS-1]};
    rem_sub = rem_sh - {1'b0, den};
    fits = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == cdr_pkg::DCNT_BITS'(cdr_pkg::RATE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? rem_sub : rem_sh;
      quo <= {quo[cdr_pkg::RATE_BITS-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;
  assign rsp.rem_nz = |rem;
endmodule
`default_nettype wire

@@ hdl/clock_mux_divider_rate_select_core.sv @@
// clock mux / divider rate select core
// input channel s_axis: tuser carries the item kind (set target rate, load a
// parent rate entry, set the gate), tdata carries the operands
// output channel m_axis: one result item per input item, with status in
// tuser and the select field, divider field, current rate and gate in tdata
// config port: cfg_we/cfg_addr/cfg_data write mux_width (0) or div_width (1)
// every item ends with one division for the current rate; a rate request
// walks the parent table, each entry costing up to two divisions
// (ceil(p/target) and p/div) plus a compare, for up to eight parents;
// all of these divisions run on the shared serial divider
// throughput: one item at a time, s_axis_tready is high only while idle
// a finished result sits in the output register; if the receiver stalls the
// next item may be accepted and worked, holding in its last step until the
// output register frees up
// reset clears the parent table, the fields, the gate and both widths
`default_nettype none
module clock_mux_divider_rate_select_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // target_rate[31:0], parent_index[34:32], parent_value[66:35], gate_enable[67]
  input  wire logic [71:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // mux_select[2:0], divider_field[10:3], current_rate[42:11], gate_off[43]
  output logic [47:0]      m_axis_tdata,
  // status[0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [3:0]  cfg_data
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_DIV2  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_RATE  = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam int SB = cdr_pkg::SEL_BITS;
  localparam int DB = cdr_pkg::DIV_BITS;

  logic [3:0] state;
  logic [1:0] mux_width;
  logic [3:0] div_width;

  cdr_pkg::rate_t parents [cdr_pkg::PARENT_COUNT];
  logic [SB-1:0] select_field;
  logic [DB-1:0] divisor_field;
  logic gate_closed;

  // item operands
  cdr_pkg::rate_t target;
  logic status;

  // search state
  logic [SB-1:0] idx;
  cdr_pkg::rate_t p;
  logic [DB:0] div;
  cdr_pkg::rate_t now;
  cdr_pkg::rate_t win_rate;
  logic [DB:0] win_div;
  logic [SB-1:0] win_sel;
  logic [SB-1:0] out_sel;
  logic [DB-1:0] out_dfield;

  logic out_valid;
  logic [47:0] out_data;
  logic out_status;

  cdr_pkg::div_req_t dreq;
  cdr_pkg::div_rsp_t drsp;

  // effective widths and masks
  logic [3:0] dw;
  logic [SB-1:0] sfld_mask;
  logic [DB:0] div_max;
  logic [DB-1:0] dfld_mask;
  logic mw_zero;
  logic dw_zero;
  logic [DB:0] ceil_div;
  logic [DB:0] div_m1;
  logic [DB:0] bdiv_m1;
  cdr_pkg::rate_t diff_now;
  cdr_pkg::rate_t diff_best;
  logic [SB-1:0] fetch_idx;
  logic [SB-1:0] rd_sel;
  logic [DB-1:0] rd_dfield;
  logic out_free;

  always_comb begin
    dw = (div_width > 4'(cdr_pkg::MAX_DIV_BITS)) ? 4'(cdr_pkg::MAX_DIV_BITS) : div_width;
    sfld_mask = SB'((1 << mux_width) - 1);
    div_max = (DB + 1)'(1) << dw;
    dfld_mask = DB'(div_max - 1'b1);
    mw_zero = mux_width == 2'd0;
    dw_zero = dw == 4'd0;
    fetch_idx = mw_zero ? '0 : idx;
    // clamp ceil(p/target) to the largest divisor
    if (drsp.quo >= cdr_pkg::RATE_BITS'(div_max)) begin
      ceil_div = div_max;
    end else begin
      ceil_div = drsp.quo[DB:0] + (DB + 1)'(drsp.rem_nz);
    end
    div_m1 = ceil_div - 1'b1;
    bdiv_m1 = win_div - 1'b1;
    diff_now = (target > now) ? target - now : now - target;
    diff_best = (target > win_rate) ? target - win_rate : win_rate - target;
    rd_sel = select_field & sfld_mask;
    rd_dfield = divisor_field & dfld_mask;
    out_free = !out_valid || m_axis_tready;
  end

  // divider requests
  always_comb begin
    dreq.start = 1'b0;
    dreq.num = p;
    dreq.den = target;
    unique case (state)
      S_FETCH: begin
        dreq.num = parents[fetch_idx];
        dreq.start = !dw_zero && (mw_zero || parents[fetch_idx] != '0);
      end
      S_DIV1: begin
        dreq.den = cdr_pkg::RATE_BITS'(ceil_div);
        dreq.start = drsp.done && !mw_zero;
      end
      S_RATE: begin
        dreq.num = parents[rd_sel];
        dreq.den = cdr_pkg::RATE_BITS'(rd_dfield) + 1'b1;
        dreq.start = 1'b1;
      end
      default: ;
    endcase
  end

  cdr_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  assign s_axis_tready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_width <= '0;
      div_width <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cdr_pkg::REG_MUX_WIDTH: mux_width <= cfg_data[1:0];
        cdr_pkg::REG_DIV_WIDTH: div_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < cdr_pkg::PARENT_COUNT; k++) parents[k] <= '0;
      select_field <= '0;
      divisor_field <= '0;
      gate_closed <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            target <= s_axis_tdata[31:0];
            idx <= '0;
            win_rate <= '0;
            win_div <= '0;
            win_sel <= '0;
            unique case (s_axis_tuser)
              cdr_pkg::KIND_RATE: begin
                if (s_axis_tdata[31:0] == '0 || (mux_width == 2'd0 && dw_zero)) begin
                  status <= 1'b1;
                  state <= S_RATE;
                end else begin
                  status <= 1'b0;
                  state <= S_FETCH;
                end
              end
              cdr_pkg::KIND_PARENT: begin
                parents[s_axis_tdata[34:32]] <= s_axis_tdata[66:35];
                status <= 1'b0;
                state <= S_RATE;
              end
              cdr_pkg::KIND_GATE: begin
                gate_closed <= !s_axis_tdata[67];
                status <= 1'b0;
                state <= S_RATE;
              end
              default: begin
                status <= 1'b1;
                state <= S_RATE;
              end
            endcase
          end
        end
        S_FETCH: begin
          p <= parents[fetch_idx];
          if (dreq.start) begin
            state <= S_DIV1;
          end else if (parents[fetch_idx] == '0) begin
            if (idx == sfld_mask) state <= S_FIN;
            else idx <= idx + 1'b1;
          end else begin
            // mux only: score the parent itself
            now <= parents[fetch_idx];
            state <= S_CMP;
          end
        end
        S_DIV1: begin
          if (drsp.done) begin
            div <= ceil_div;
            if (mw_zero) begin
              divisor_field <= (divisor_field & ~dfld_mask) | (div_m1[DB-1:0] & dfld_mask);
              state <= S_RATE;
            end else begin
              state <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (drsp.done) begin
            now <= drsp.quo;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (diff_now < diff_best) begin
            win_rate <= now;
            win_div <= div;
            win_sel <= idx;
          end
          if (idx == sfld_mask) state <= S_FIN;
          else begin
            idx <= idx + 1'b1;
            state <= S_FETCH;
          end
        end
        S_FIN: begin
          // nothing found: parent zero, and for the combined search the largest divisor
          if (win_rate == '0) begin
            select_field <= select_field & ~sfld_mask;
            if (!dw_zero) begin
              divisor_field <= (divisor_field & ~dfld_mask) |
                               (DB'(div_max - 1'b1) & dfld_mask);
            end
          end else begin
            select_field <= (select_field & ~sfld_mask) | (win_sel & sfld_mask);
            if (!dw_zero) begin
              divisor_field <= (divisor_field & ~dfld_mask) | (bdiv_m1[DB-1:0] & dfld_mask);
            end
          end
          state <= S_RATE;
        end
        S_RATE: begin
          out_sel <= rd_sel;
          out_dfield <= rd_dfield;
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          if (drsp.done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register valid: set as the item leaves, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded as the item leaves
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= {4'd0, gate_closed, drsp.quo, out_dfield, out_sel};
      out_status <= status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;
  assign m_axis_tuser = out_status;
endmodule
`default_nettype wire

@@ hdl/cdr_chk.sv @@
`default_nettype none
`include "clock_mux_divider_rate_select_core_assert.svh"
module cdr_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  // a stalled result stays offered
  `CDR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // one item at a time
  `CDR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // no result right after reset
  `CDR_ASSERT_ALWAYS(a_reset_quiet, rst, !m_axis_tvalid)
  // spare output bits stay zero
  `CDR_ASSERT_NEXT(a_pad_zero, m_axis_tvalid, m_axis_tdata[47:44] == 4'd0 || !m_axis_tvalid)
endmodule

bind clock_mux_divider_rate_select_core cdr_chk u_cdr_chk (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ verif/rate_select_checker.sv @@
`default_nettype none
module rate_select_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [3:0]  cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       status;
    logic [2:0] sel;
    logic [7:0] dfield;
    logic [31:0] rate;
    logic       gate_off;
  } rate_result_t;

  rate_result_t expected_results[$];
  logic [31:0] parents [cdr_pkg::PARENT_COUNT];
  logic [2:0]  sel_q;
  logic [7:0]  div_q;
  logic        gate_q;
  logic [1:0]  mux_w;
  logic [3:0]  div_w;

  function automatic logic [63:0] absdiff(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [63:0] ceil_quot(logic [63:0] n, logic [63:0] d);
    return n / d + ((n % d) != 0 ? 64'd1 : 64'd0);
  endfunction

  // apply one rate request to the shadow fields, return status
  function automatic logic select_rate(logic [63:0] target);
    int mw, dw;
    logic [31:0] smask, dmask;
    logic [63:0] dmax, win_rate, win_div, p, dv, now;
    logic [31:0] win_sel;
    mw = (mux_w > 3) ? 3 : mux_w;
    dw = (div_w > 8) ? 8 : div_w;
    smask = (32'd1 << mw) - 1;
    dmask = (32'd1 << dw) - 1;
    dmax = {32'd0, dmask} + 64'd1;
    win_rate = 0;
    win_div = 0;
    win_sel = 0;
    if (target == 0 || (mw == 0 && dw == 0)) return 1'b1;
    if (mw == 0) begin
      dv = ceil_quot({32'd0, parents[0]}, target);
      if (dv > dmax) dv = dmax;
      div_q = (div_q & ~dmask[7:0]) | (8'(dv - 1) & dmask[7:0]);
    end else begin
      for (int i = 0; i <= smask; i++) begin
        p = {32'd0, parents[i]};
        if (p == 0) continue;
        if (dw == 0) begin
          now = p;
        end else begin
          dv = ceil_quot(p, target);
          if (dv > dmax) dv = dmax;
          now = p / dv;
        end
        if (absdiff(target, now) < absdiff(target, win_rate)) begin
          win_rate = now;
          win_div = dv;
          win_sel = i;
        end
      end
      if (win_rate == 0) begin
        win_sel = 0;
        win_div = dmax;
      end
      sel_q = (sel_q & ~smask[2:0]) | (win_sel[2:0] & smask[2:0]);
      if (dw != 0) div_q = (div_q & ~dmask[7:0]) | (8'(win_div - 1) & dmask[7:0]);
    end
    return 1'b0;
  endfunction

  function automatic rate_result_t predict_item(logic [1:0] kind, logic [71:0] d);
    rate_result_t r;
    int mw, dw;
    r.status = 1'b0;
    case (kind)
      cdr_pkg::KIND_RATE:   r.status = select_rate({32'd0, d[31:0]});
      cdr_pkg::KIND_PARENT: parents[d[34:32]] = d[66:35];
      cdr_pkg::KIND_GATE:   gate_q = ~d[67];
      default:              r.status = 1'b1;
    endcase
    mw = (mux_w > 3) ? 3 : mux_w;
    dw = (div_w > 8) ? 8 : div_w;
    r.sel = sel_q & 3'((1 << mw) - 1);
    r.dfield = div_q & 8'((1 << dw) - 1);
    r.rate = parents[r.sel] / ({24'd0, r.dfield} + 32'd1);
    r.gate_off = gate_q;
    return r;
  endfunction

  always @(posedge clk) begin
    rate_result_t got, exp_r;
    if (rst) begin
      for (int i = 0; i < cdr_pkg::PARENT_COUNT; i++) parents[i] = '0;
      sel_q = 0; div_q = 0; gate_q = 0; mux_w = 0; div_w = 0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == cdr_pkg::REG_MUX_WIDTH) mux_w = cfg_data[1:0];
        else div_w = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_item(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3],
               m_axis_tdata[42:11], m_axis_tdata[43]};
        if (expected_results.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.sel !== exp_r.sel) begin
            $error("mux_select exp %0d got %0d", exp_r.sel, got.sel); errors++;
          end
          if (got.dfield !== exp_r.dfield) begin
            $error("divider_field exp %0d got %0d", exp_r.dfield, got.dfield); errors++;
          end
          if (got.rate !== exp_r.rate) begin
            $error("current_rate exp %0d got %0d", exp_r.rate, got.rate); errors++;
          end
          if (got.gate_off !== exp_r.gate_off) begin
            $error("gate_off exp %0d got %0d", exp_r.gate_off, got.gate_off); errors++;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule
`default_nettype wire

@@ verif/tb_clock_mux_divider_rate_select_core.sv @@
`default_nettype none
module tb_clock_mux_divider_rate_select_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  // target_rate[31:0], parent_index[34:32], parent_value[66:35], gate_enable[67]
  logic [71:0] s_axis_tdata = '0;
  // kind[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  // mux_select[2:0], divider_field[10:3], current_rate[42:11], gate_off[43]
  logic [47:0] m_axis_tdata;
  // status[0]
  logic        m_axis_tuser;
  logic        cfg_we = 0;
  logic        cfg_addr = 0;
  logic [3:0]  cfg_data = '0;
  int          errors, pending;
  int          idle_cycles = 0;
  bit          stall_long = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  clock_mux_divider_rate_select_core uut (.*);

  rate_select_checker chk (.*);

  // handful of values that land near parent rates and produce exact divides
  logic [31:0] rate_pool [8];

  // valid stays up after the accept until the next item or a pause drops it
  task automatic send_item(logic [1:0] kind, logic [71:0] data);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [71:0] pack_in(logic [31:0] tgt, logic [2:0] idx,
                                          logic [31:0] pv, logic ge);
    return {4'd0, ge, pv, idx, tgt};
  endfunction

  task automatic wait_empty();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_empty();
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [3:0] val);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = $urandom;
    if (pick < 30) begin
      send_item(cdr_pkg::KIND_PARENT, pack_in($urandom, 3'($urandom_range(0, 7)),
                (pick < 4) ? 32'd0 : ((pick < 20) ? rate_pool[$urandom_range(0, 7)] : v),
                1'($urandom_range(0, 1))));
    end else if (pick < 85) begin
      // near a parent, a fraction of one, zero, or anything
      case ($urandom_range(0, 3))
        0: v = rate_pool[$urandom_range(0, 7)] / $urandom_range(1, 300);
        1: v = rate_pool[$urandom_range(0, 7)] + $urandom_range(0, 2000) - 1000;
        2: v = (pick < 33) ? 32'd0 : $urandom_range(1, 1000);
        default: v = $urandom;
      endcase
      send_item(cdr_pkg::KIND_RATE,
                pack_in(v, 3'($urandom), $urandom, 1'($urandom_range(0, 1))));
    end else if (pick < 95) begin
      send_item(cdr_pkg::KIND_GATE,
                pack_in($urandom, 3'($urandom), $urandom, 1'($urandom_range(0, 1))));
    end else begin
      send_item(cdr_pkg::KIND_BAD, 72'({$urandom, $urandom, $urandom}));
    end
  endtask

  // receiver: random stalls per item, plus one long hold-off
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (stall_long) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk);
        stall_long = 0;
      end
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [3:0] mw_set [5];
    logic [3:0] dw_set [5];
    rate_pool = '{32'd24000000, 32'd100000000, 32'd297000000, 32'd1188000000,
                  32'd32768, 32'd4294967295, 32'd600000000, 32'd1};
    mw_set = '{4'd3, 4'd2, 4'd0, 4'd1, 4'd3};
    dw_set = '{4'd8, 4'd0, 4'd15, 4'd4, 4'd3};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: widths both zero, then extremes
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd1000, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_PARENT, pack_in(32'd0, 3'd0, 32'hFFFFFFFF, 1'b1));
    send_item(cdr_pkg::KIND_PARENT, pack_in(32'd0, 3'd7, 32'd1, 1'b0));
    send_item(cdr_pkg::KIND_GATE, pack_in(32'd0, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_GATE, pack_in(32'hFFFFFFFF, 3'd7, 32'hFFFFFFFF, 1'b1));
    send_item(cdr_pkg::KIND_BAD, {72{1'b1}});
    wait_drained();
    write_reg(cdr_pkg::REG_DIV_WIDTH, 4'd8);
    // divider only: exact, rounding up, clamp, zero target, zero parent
    send_item(cdr_pkg::KIND_RATE, pack_in(32'hFFFFFFFF, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd1, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd0, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd20000000, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_PARENT, pack_in(32'd0, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd5, 3'd0, 32'd0, 1'b0));
    wait_drained();
    write_reg(cdr_pkg::REG_MUX_WIDTH, 4'd3);
    write_reg(cdr_pkg::REG_DIV_WIDTH, 4'd0);
    // mux only: ties go to the earlier entry, zero parents skipped
    send_item(cdr_pkg::KIND_PARENT, pack_in(32'd0, 3'd2, 32'd1000, 1'b0));
    send_item(cdr_pkg::KIND_PARENT, pack_in(32'd0, 3'd5, 32'd1000, 1'b0));
    send_item(cdr_pkg::KIND_PARENT, pack_in(32'd0, 3'd6, 32'd3000, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd2000, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd2900, 3'd0, 32'd0, 1'b0));
    wait_drained();
    write_reg(cdr_pkg::REG_DIV_WIDTH, 4'd15);
    // both, wide setting clamps to eight bits
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd7, 3'd0, 32'd0, 1'b0));
    send_item(cdr_pkg::KIND_RATE, pack_in(32'd333, 3'd0, 32'd0, 1'b0));
    wait_drained();

    // random phases across settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(cdr_pkg::REG_MUX_WIDTH, mw_set[ph]);
      write_reg(cdr_pkg::REG_DIV_WIDTH, dw_set[ph]);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 10) stall_long = 1;
        if (n == 50) wait_empty();
        random_item();
      end
      wait_drained();
    end
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
